>>> rtl/core/cpl_pkg.sv
// Shared types, widths and constants for the closest-points core.
package cpl_pkg;

  localparam int unsigned CW    = 48;        // Q32.16 coordinate
  localparam int unsigned DW    = 32;        // Q2.30 direction
  localparam int unsigned RW    = CW + 1;    // origin difference
  localparam int unsigned UW    = 2*DW + 2;  // a, b, e
  localparam int unsigned RDW   = DW + RW + 2; // c, f
  localparam int unsigned DTW   = 2*UW;      // determinant
  localparam int unsigned NW    = 150;       // numerators n1, n2
  localparam int unsigned PW    = DW + NW;   // direction times numerator
  localparam int unsigned QW    = 50;        // quotient bits kept before saturation
  localparam int unsigned NL    = 6;         // output coordinates
  localparam int unsigned IN_W  = 6*CW + 6*DW;
  localparam int unsigned OUT_W = NL*CW;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] dir_t;

  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    coord_t [2:0] o1;
    dir_t   [2:0] u;
    coord_t [2:0] o2;
    dir_t   [2:0] v;
  } lines_t;

  typedef struct packed {
    logic                  found;
    lines_t                ln;
    logic signed [DTW-1:0] d;
    logic signed [NW-1:0]  n1;
    logic signed [NW-1:0]  n2;
  } job_t;

  typedef struct packed {
    logic            found;
    coord_t [NL-1:0] org;
    logic [DTW-1:0]  d;
  } carry_t;

endpackage

>>> rtl/core/cpl_mul.sv
// Four-stage signed multiplier built from registered 32x32 partial products.
module cpl_mul #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int unsigned NA = (WA + 31) / 32;
  localparam int unsigned NB = (WB + 31) / 32;
  localparam int unsigned LA = NA * 32;
  localparam int unsigned LB = NB * 32;
  localparam int unsigned LP = LA + LB;
  localparam int unsigned WP = WA + WB;

  logic [WA-1:0] ma;
  logic [WB-1:0] mb;
  logic [LA-1:0] ma_q;
  logic [LB-1:0] mb_q;
  logic          s1_q, s2_q, s3_q;
  logic [63:0]   pp_q [NA][NB];
  logic [LP-1:0] acc, sum_q;
  logic [WP-1:0] p_q;

  assign ma = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
  assign mb = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (LP'(pp_q[i][j]) << (32*(i+j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q <= LA'(ma);
      mb_q <= LB'(mb);
      s1_q <= a_i[WA-1] ^ b_i[WB-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= 64'(ma_q[32*i +: 32]) * 64'(mb_q[32*j +: 32]);
        end
      end
      s2_q  <= s1_q;
      sum_q <= acc;
      s3_q  <= s2_q;
      p_q   <= s3_q ? WP'(-sum_q) : WP'(sum_q);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/cpl_front.sv
// Front pipeline: dot products, determinant and both numerators.
module cpl_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [cpl_pkg::IN_W-1:0]  in_data_i,
  input  logic                      full_i,
  output logic                      push_o,
  output cpl_pkg::job_t             job_o
);
  import cpl_pkg::*;

  localparam int unsigned NS = 11;

  logic              en;
  logic [NS-1:0]     vld_q;
  lines_t            ln_in;
  lines_t            ln_q [NS];
  logic signed [RW-1:0]     r_q [3];
  logic signed [2*DW-1:0]   p_uu [3], p_uv [3], p_vv [3];
  logic signed [DW+RW-1:0]  p_ur [3], p_vr [3];
  logic signed [UW-1:0]     a_q, b_q, e_q;
  logic signed [RDW-1:0]    c_q, f_q;
  logic signed [DTW-1:0]    p_ae, p_bb, d_c, d_q;
  logic signed [UW+RDW-1:0] p_bf, p_ce, p_af, p_cb;
  logic signed [NW-1:0]     n1_q, n2_q;
  logic                     found_q;

  // stall only when the finished word cannot enter the queue
  assign en         = !(vld_q[NS-1] && full_i);
  assign in_ready_o = en;
  assign push_o     = vld_q[NS-1] && !full_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ln_in.o1[k] = in_data_i[CW*k +: CW];
      ln_in.u[k]  = in_data_i[3*CW + DW*k +: DW];
      ln_in.o2[k] = in_data_i[3*CW + 3*DW + CW*k +: CW];
      ln_in.v[k]  = in_data_i[6*CW + 3*DW + DW*k +: DW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ln_q[0] <= ln_in;
      for (int i = 1; i < NS; i++) ln_q[i] <= ln_q[i-1];
      for (int k = 0; k < 3; k++) begin
        r_q[k] <= RW'($signed(ln_in.o1[k])) - RW'($signed(ln_in.o2[k]));
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_dot
    cpl_mul #(.WA(DW), .WB(DW)) u_uu (.clk_i, .en_i(en),
      .a_i(ln_q[0].u[k]), .b_i(ln_q[0].u[k]), .p_o(p_uu[k]));
    cpl_mul #(.WA(DW), .WB(DW)) u_uv (.clk_i, .en_i(en),
      .a_i(ln_q[0].u[k]), .b_i(ln_q[0].v[k]), .p_o(p_uv[k]));
    cpl_mul #(.WA(DW), .WB(DW)) u_vv (.clk_i, .en_i(en),
      .a_i(ln_q[0].v[k]), .b_i(ln_q[0].v[k]), .p_o(p_vv[k]));
    cpl_mul #(.WA(DW), .WB(RW)) u_ur (.clk_i, .en_i(en),
      .a_i(ln_q[0].u[k]), .b_i(r_q[k]), .p_o(p_ur[k]));
    cpl_mul #(.WA(DW), .WB(RW)) u_vr (.clk_i, .en_i(en),
      .a_i(ln_q[0].v[k]), .b_i(r_q[k]), .p_o(p_vr[k]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= UW'(p_uu[0]) + UW'(p_uu[1]) + UW'(p_uu[2]);
      b_q <= UW'(p_uv[0]) + UW'(p_uv[1]) + UW'(p_uv[2]);
      e_q <= UW'(p_vv[0]) + UW'(p_vv[1]) + UW'(p_vv[2]);
      c_q <= RDW'(p_ur[0]) + RDW'(p_ur[1]) + RDW'(p_ur[2]);
      f_q <= RDW'(p_vr[0]) + RDW'(p_vr[1]) + RDW'(p_vr[2]);
    end
  end

  cpl_mul #(.WA(UW), .WB(UW))   u_ae (.clk_i, .en_i(en), .a_i(a_q), .b_i(e_q), .p_o(p_ae));
  cpl_mul #(.WA(UW), .WB(UW))   u_bb (.clk_i, .en_i(en), .a_i(b_q), .b_i(b_q), .p_o(p_bb));
  cpl_mul #(.WA(UW), .WB(RDW))  u_bf (.clk_i, .en_i(en), .a_i(b_q), .b_i(f_q), .p_o(p_bf));
  cpl_mul #(.WA(RDW), .WB(UW))  u_ce (.clk_i, .en_i(en), .a_i(c_q), .b_i(e_q), .p_o(p_ce));
  cpl_mul #(.WA(UW), .WB(RDW))  u_af (.clk_i, .en_i(en), .a_i(a_q), .b_i(f_q), .p_o(p_af));
  cpl_mul #(.WA(RDW), .WB(UW))  u_cb (.clk_i, .en_i(en), .a_i(c_q), .b_i(b_q), .p_o(p_cb));

  assign d_c = p_ae - p_bb;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q     <= d_c;
      found_q <= d_c != '0;
      n1_q    <= NW'(p_bf) - NW'(p_ce);
      n2_q    <= NW'(p_af) - NW'(p_cb);
    end
  end

  always_comb begin
    job_o.found = found_q;
    job_o.ln    = ln_q[NS-1];
    job_o.d     = d_q;
    job_o.n1    = n1_q;
    job_o.n2    = n2_q;
  end

endmodule

>>> rtl/core/cpl_fifo.sv
// Short queue of finished front words in front of the divider pipeline.
module cpl_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cpl_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output cpl_pkg::job_t data_o,
  output logic          empty_o
);
  import cpl_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNW = $clog2(DEPTH + 1);

  job_t           mem_q [DEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CNW-1:0] cnt_q;

  assign full_o  = cnt_q == CNW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CNW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CNW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

>>> rtl/core/cpl_back.sv
// Back pipeline: offsets, bit-per-stage division, rounding and saturation.
module cpl_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cpl_pkg::job_t             job_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output logic [cpl_pkg::OUT_W-1:0] m_data_o,
  output logic                      m_found_o
);
  import cpl_pkg::*;

  localparam int unsigned S_MAG = 5;
  localparam int unsigned S_DIV = 6;
  localparam int unsigned S_RND = S_DIV + QW + 1;
  localparam int unsigned S_OUT = S_RND + 1;
  localparam int unsigned NS    = S_OUT + 1;
  localparam int unsigned SW    = QW + 3;

  logic                 en;
  logic [NS-1:0]        bv_q;
  carry_t               cr_q [NS];
  dir_t                 dir_q [NL];
  logic signed [NW-1:0] n_q [2];
  logic signed [PW-1:0] p_w [NL];
  logic [PW-1:0]        mag_q [NL];
  logic                 sg_q [NL];
  logic [PW-1:0]        rem_q [NL][QW+1];
  logic [QW-1:0]        q_q [NL][QW+1];
  logic                 neg_q [NL][QW+1];
  logic                 ovf_q [NL][QW+1];
  logic [QW:0]          qr_q [NL];
  logic                 ngr_q [NL], ovr_q [NL];
  coord_t               pt_q [NL];

  assign en        = !bv_q[NS-1] || m_ready_i;
  assign pop_o     = en && !empty_i;
  assign m_valid_o = bv_q[NS-1];
  assign m_found_o = cr_q[S_OUT].found;

  always_comb begin
    for (int k = 0; k < NL; k++) m_data_o[CW*k +: CW] = pt_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else if (en) begin
      bv_q <= {bv_q[NS-2:0], !empty_i};
    end
  end

  for (genvar k = 0; k < NL; k++) begin : g_off
    cpl_mul #(.WA(DW), .WB(NW)) u_mul (.clk_i, .en_i(en),
      .a_i(dir_q[k]), .b_i(n_q[k/3]), .p_o(p_w[k]));
  end

  always_ff @(posedge clk_i) begin
    logic [PW-1:0]  dsh;
    logic signed [SW-1:0] off, sum;
    if (en) begin
      cr_q[0].found <= job_i.found;
      cr_q[0].d     <= job_i.d;
      for (int k = 0; k < 3; k++) begin
        cr_q[0].org[k]   <= job_i.ln.o1[k];
        cr_q[0].org[k+3] <= job_i.ln.o2[k];
        dir_q[k]         <= job_i.ln.u[k];
        dir_q[k+3]       <= job_i.ln.v[k];
      end
      n_q[0] <= job_i.n1;
      n_q[1] <= job_i.n2;
      for (int i = 1; i < NS; i++) cr_q[i] <= cr_q[i-1];

      for (int k = 0; k < NL; k++) begin
        mag_q[k] <= p_w[k][PW-1] ? PW'(-p_w[k]) : PW'(p_w[k]);
        sg_q[k]  <= p_w[k][PW-1];

        // quotient at or beyond 2^QW saturates the point unless the lines are parallel
        rem_q[k][0] <= mag_q[k];
        q_q[k][0]   <= '0;
        neg_q[k][0] <= sg_q[k];
        ovf_q[k][0] <= mag_q[k] >= (PW'(cr_q[S_MAG].d) << QW);

        for (int i = 1; i <= QW; i++) begin
          dsh = PW'(cr_q[S_DIV+i-1].d) << (QW - i);
          if (rem_q[k][i-1] >= dsh) begin
            rem_q[k][i] <= rem_q[k][i-1] - dsh;
            q_q[k][i]   <= q_q[k][i-1] | (QW'(1) << (QW - i));
          end else begin
            rem_q[k][i] <= rem_q[k][i-1];
            q_q[k][i]   <= q_q[k][i-1];
          end
          neg_q[k][i] <= neg_q[k][i-1];
          ovf_q[k][i] <= ovf_q[k][i-1];
        end

        // round half away from zero on the magnitude
        qr_q[k]  <= (QW+1)'(q_q[k][QW]) +
                    (QW+1)'({rem_q[k][QW], 1'b0} >= (PW+1)'(cr_q[S_RND-1].d));
        ngr_q[k] <= neg_q[k][QW];
        ovr_q[k] <= ovf_q[k][QW];

        off = ngr_q[k] ? -SW'(qr_q[k]) : SW'(qr_q[k]);
        sum = SW'($signed(cr_q[S_RND].org[k])) + off;
        if (!cr_q[S_RND].found)      pt_q[k] <= '0;
        else if (ovr_q[k])           pt_q[k] <= ngr_q[k] ? C_MIN : C_MAX;
        else if (sum > SW'(C_MAX))   pt_q[k] <= C_MAX;
        else if (sum < SW'(C_MIN))   pt_q[k] <= C_MIN;
        else                         pt_q[k] <= CW'(sum);
      end
    end
  end

endmodule

>>> rtl/core/closest_points_two_lines_core.sv
// Closest points between two 3-D lines: one line pair in, one point pair out.
//
// Slave stream s_axis carries one line pair per word (origins Q32.16,
// directions Q2.30). Master stream m_axis returns both closest points as
// Q32.16, saturated, with tuser[0] set when the lines are not parallel;
// parallel lines return all points as zero.
// Throughput is one word per cycle while the receiver does not stall. A word
// passes through the front pipeline (dot products, determinant, numerators
// through 32x32 partial-product multipliers), then the queue, then the
// back pipeline, where the divider retires one quotient bit per stage for
// 50 stages.
// A queue of QUEUE_DEPTH words parts the two halves. When the receiver
// stalls, the back pipeline holds its output word; the front keeps
// accepting until a finished word meets a full queue, then drops s_axis_tready.
// Reset clears all valid bits and the queue; no word is in flight after it.
module closest_points_two_lines_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // o1 x,y,z (48 each), u x,y,z (32 each), o2 x,y,z (48 each), v x,y,z (32 each)
  input  logic [cpl_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // first point x,y,z, second point x,y,z (48 each)
  output logic [cpl_pkg::OUT_W-1:0] m_axis_tdata,
  // found
  output logic [0:0]                m_axis_tuser
);
  import cpl_pkg::*;

  logic full, empty, push, pop, found;
  job_t job_f, job_b;

  cpl_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .full_i(full), .push_o(push), .job_o(job_f)
  );

  cpl_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(job_f), .full_o(full),
    .pop_i(pop), .data_o(job_b), .empty_o(empty)
  );

  cpl_back u_back (
    .clk_i, .rst_ni,
    .job_i(job_b), .empty_i(empty), .pop_o(pop),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_o(m_axis_tdata), .m_found_o(found)
  );

  assign m_axis_tuser = found;

  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("parallel result carries nonzero points");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> full)
    else $error("front stalled while queue has room");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("back pulled from an empty queue");

endmodule
